FILE: rtl/rast_pkg.sv
package rast_pkg;

    // Array geometry
    localparam int BKT_SPAN     = 256;
    localparam int MAX_LENGTH   = 4096;
    localparam int BUCKET_COUNT = (MAX_LENGTH + BKT_SPAN - 1) / BKT_SPAN;

    // Field widths
    localparam int IDX_W  = 12;
    localparam int LEN_W  = 13;
    localparam int DATA_W = 32;
    localparam int ACT_W  = 2;
    localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Action codes on the input stream; the unused code behaves as a read
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ASSIGN = 2'd1,
        ACT_READ   = 2'd2
    } action_t;

    // Work kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_SCAN,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [IDX_W-1:0]         lo;
        logic [IDX_W-1:0]         top;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         pos;
    } cmd_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SCAN,
        BS_FLUSH,
        BS_READ,
        BS_DONE
    } back_state_t;

    // Bucket that holds a given element
    function automatic logic [BKT_W-1:0] bucket_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] quot;
        quot = idx / IDX_W'(BKT_SPAN);
        return quot[BKT_W-1:0];
    endfunction

endpackage

FILE: rtl/rast_front.sv
module rast_front
    import rast_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [LEN_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    input  logic [ACT_W-1:0]         in_action,
    input  logic [IDX_W-1:0]         in_lo,
    input  logic [IDX_W-1:0]         in_hi,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic [IDX_W-1:0]         in_pos,
    output logic                     cmd_valid,
    output cmd_t                     cmd
);

    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] len_m1;
    logic [LEN_W-1:0] hi_ext;
    logic [LEN_W-1:0] top_len;
    logic [LEN_W-1:0] top_clamp;
    logic             range_empty;

    // Hold the element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= '0;
        else if (cfg_we)
            length_reg <= cfg_wdata;
    end

    // Clamp the high index to the used length and to the capacity
    always_comb
    begin
        len_m1  = length_reg - LEN_W'(1);
        hi_ext  = {1'b0, in_hi};
        top_len = (hi_ext < len_m1) ? hi_ext : len_m1;
        if (top_len > LEN_W'(MAX_LENGTH - 1))
            top_clamp = LEN_W'(MAX_LENGTH - 1);
        else
            top_clamp = top_len;
        range_empty = (length_reg == '0) || ({1'b0, in_lo} > top_clamp);
    end

    // Classify the item into a back-end command
    always_comb
    begin
        cmd.lo    = in_lo;
        cmd.top   = top_clamp[IDX_W-1:0];
        cmd.value = in_value;
        cmd.pos   = in_pos;
        unique case (in_action)
            ACT_LOAD:   cmd.kind = CMD_LOAD;
            ACT_ASSIGN: cmd.kind = range_empty ? CMD_READ : CMD_SCAN;
            default:    cmd.kind = CMD_READ;
        endcase
        cmd_valid = in_valid;
    end

endmodule

FILE: rtl/rast_queue.sv
module rast_queue
    import rast_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: rtl/rast_back.sv
module rast_back
    import rast_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  cmd_t                     cmd,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_total,
    output logic signed [DATA_W-1:0] out_point
);

    // Element memory
    logic [DATA_W-1:0] mem [MAX_LENGTH];
    logic [DATA_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;

    back_state_t              state_reg, state_next;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]         top_reg, top_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]         pend_addr_reg, pend_addr_next;
    logic [DATA_W-1:0]        total_reg, total_next;
    logic [DATA_W-1:0]        bucket_reg [BUCKET_COUNT];
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_total_reg, out_total_next;
    logic signed [DATA_W-1:0] out_point_reg, out_point_next;

    logic              bkt_en;
    logic [BKT_W-1:0]  bkt_idx;
    logic [DATA_W-1:0] bkt_delta;

    assign cmd_ready = (state_reg == BS_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;
    assign out_point = out_point_reg;
    assign total_next = total_reg + bkt_delta;

    // Sequence loads, range scans and point reads
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        top_next        = top_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_total_next  = out_total_reg;
        out_point_next  = out_point_reg;

        // Retire the element read in the previous cycle
        mem_we    = pend_valid_reg;
        mem_waddr = pend_addr_reg;
        mem_wdata = value_reg;
        mem_raddr = scan_idx_reg;
        bkt_en    = pend_valid_reg;
        bkt_idx   = bucket_of(pend_addr_reg);
        bkt_delta = pend_valid_reg ? (value_reg - mem_rdata_reg) : '0;

        unique case (state_reg)
            BS_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    scan_idx_next = cmd.lo;
                    top_next      = cmd.top;
                    value_next    = cmd.value;
                    pos_next      = cmd.pos;
                    unique case (cmd.kind)
                        CMD_LOAD:
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = cmd.pos;
                            mem_wdata      = cmd.value;
                            bkt_en         = 1'b1;
                            bkt_idx        = bucket_of(cmd.pos);
                            bkt_delta      = cmd.value;
                            out_valid_next = 1'b1;
                            out_total_next = total_reg + cmd.value;
                            out_point_next = cmd.value;
                        end
                        CMD_SCAN:
                            state_next = BS_SCAN;
                        default:
                            state_next = BS_READ;
                    endcase
                end
            end
            BS_SCAN:
            begin
                pend_valid_next = 1'b1;
                pend_addr_next  = scan_idx_reg;
                mem_raddr       = scan_idx_reg;
                if (scan_idx_reg == top_reg)
                    state_next = BS_FLUSH;
                else
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
            BS_FLUSH:
                state_next = BS_READ;
            BS_READ:
            begin
                mem_raddr  = pos_reg;
                state_next = BS_DONE;
            end
            BS_DONE:
            begin
                out_valid_next = 1'b1;
                out_total_next = total_reg;
                out_point_next = mem_rdata_reg;
                state_next     = BS_IDLE;
            end
            default:
                state_next = BS_IDLE;
        endcase
    end

    // Control and sum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BS_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            total_reg      <= '0;
            for (int b = 0; b < BUCKET_COUNT; b++)
                bucket_reg[b] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (bkt_en)
            begin
                bucket_reg[bkt_idx] <= bucket_reg[bkt_idx] + bkt_delta;
                total_reg           <= total_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        top_reg       <= top_next;
        value_reg     <= value_next;
        pos_reg       <= pos_next;
        pend_addr_reg <= pend_addr_next;
        out_total_reg <= out_total_next;
        out_point_reg <= out_point_next;
    end

    // Element memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

endmodule

FILE: rtl/range_assign_sum_table_core.sv
// Range-assign / total-sum table with 4096 signed 32-bit elements in 16 buckets.
// Input stream s_*: tuser carries the action (0 load, 1 range assign, other
// codes read only); tdata carries lo_index, hi_index, data_value, position.
// Output stream m_*: one item per input item with the wrapped total and the
// element at position after that item took effect.
// cfg_we/cfg_wdata set the element count; write it only while the block is idle.
// Items pass a two-entry command queue, so the input side keeps accepting while
// the back end works or the output waits.
// Back-end steps from taking a command to the result register: a load goes there
//   directly, a read only passes BS_READ and BS_DONE, a range assign passes
// BS_SCAN, BS_FLUSH, BS_READ and BS_DONE. The element memory has one write port and
// one registered read port and retires one element per cycle during BS_SCAN.
// Reset clears the bucket sums, the total, the element count and the command
// queue; element contents are undefined until written.
// When m_tready is low the result is held and the back end takes no further
// command until it is taken; the queue then fills and s_tready drops.
module range_assign_sum_table_core
    import rast_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,   // array_length
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [71:0]      s_tdata,     // lo_index, hi_index, data_value, position
    input  logic [ACT_W-1:0] s_tuser,     // action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata      // total_sum, point_value
);

    logic                     front_valid;
    cmd_t                     front_cmd;
    logic                     q_valid;
    logic                     q_ready;
    cmd_t                     q_cmd;
    logic signed [DATA_W-1:0] res_total;
    logic signed [DATA_W-1:0] res_point;

    rast_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_lo     (s_tdata[11:0]),
        .in_hi     (s_tdata[23:12]),
        .in_value  (s_tdata[55:24]),
        .in_pos    (s_tdata[67:56]),
        .cmd_valid (front_valid),
        .cmd       (front_cmd)
    );

    rast_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (s_tready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    rast_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_total (res_total),
        .out_point (res_point)
    );

    assign m_tdata = {res_point, res_total};

endmodule

FILE: tb/sv/tb_range_assign_sum_table_core.sv
module tb_range_assign_sum_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rast_pkg::*;

    // Unused action code, behaves as a read
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] point_value;
        logic [DATA_W-1:0] total_sum;
    } sum_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [71:0]      s_tdata = '0;    // lo_index, hi_index, data_value, position
    logic [ACT_W-1:0] s_tuser = '0;    // action
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [63:0]      m_tdata;         // total_sum, point_value

    // Mirror of the block state
    logic [DATA_W-1:0] elem_mirror [MAX_LENGTH];
    logic [DATA_W-1:0] bucket_mirror [BUCKET_COUNT];
    bit                written_mask [MAX_LENGTH];
    int                written_idx [$];
    int                len_mirror;

    sum_result_t pending_sums [$];

    bit quiet_run = 1'b0;
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int assigns_sent = 0;
    int elems_rewritten = 0;
    int fill_cursor = 0;

    range_assign_sum_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random unless in a quiet stretch
    always @(posedge clk)
    begin
        m_tready <= quiet_run ? 1'b1 : ($urandom_range(0, 99) >= 26);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        sum_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_sums.size() == 0)
            begin
                $error("result with no item pending: total_sum %h point_value %h",
                       m_tdata[31:0], m_tdata[63:32]);
                fail_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (m_tdata[31:0] !== want.total_sum)
                begin
                    $error("total_sum expected %h actual %h", want.total_sum, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.point_value)
                begin
                    $error("point_value expected %h actual %h",
                           want.point_value, m_tdata[63:32]);
                    fail_count++;
                end
            end
        end
    end

    // Last index a range assign may touch; -1 when nothing is in use
    function automatic int clamped_top(input logic [IDX_W-1:0] hi);
        int top;
        if (len_mirror == 0)
            return -1;
        top = int'(hi);
        if (top > len_mirror - 1)
            top = len_mirror - 1;
        if (top > MAX_LENGTH - 1)
            top = MAX_LENGTH - 1;
        return top;
    endfunction

    // An item is legal when it never reads an element that was never written
    function automatic bit item_legal(input logic [ACT_W-1:0] act,
                                      input logic [IDX_W-1:0] lo,
                                      input logic [IDX_W-1:0] hi,
                                      input logic [IDX_W-1:0] pos);
        int top;
        if (act != ACT_LOAD && !written_mask[pos])
            return 1'b0;
        if (act == ACT_ASSIGN)
        begin
            top = clamped_top(hi);
            for (int j = int'(lo); j <= top; j++)
                if (!written_mask[j])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int random_written();
        return written_idx[$urandom_range(0, written_idx.size() - 1)];
    endfunction

    // Advance the mirror by one item and queue the expected sums
    task automatic predict_sums(input logic [ACT_W-1:0] act,
                                input logic [IDX_W-1:0] lo,
                                input logic [IDX_W-1:0] hi,
                                input logic [DATA_W-1:0] value,
                                input logic [IDX_W-1:0] pos);
        int top;
        int bkt;
        sum_result_t want;
        if (act == ACT_LOAD)
        begin
            if (!written_mask[pos])
            begin
                written_mask[pos] = 1'b1;
                written_idx = {written_idx, int'(pos)};
            end
            elem_mirror[pos] = value;
            bkt = pos / BKT_SPAN;
            bucket_mirror[bkt] = bucket_mirror[bkt] + value;
        end
        else if (act == ACT_ASSIGN)
        begin
            assigns_sent++;
            top = clamped_top(hi);
            for (int j = int'(lo); j <= top; j++)
            begin
                bkt = j / BKT_SPAN;
                bucket_mirror[bkt] = bucket_mirror[bkt] - elem_mirror[j] + value;
                elem_mirror[j] = value;
                elems_rewritten++;
            end
        end
        want.total_sum = '0;
        for (int b = 0; b < BUCKET_COUNT; b++)
            want.total_sum = want.total_sum + bucket_mirror[b];
        want.point_value = written_mask[pos] ? elem_mirror[pos] : '0;
        pending_sums = {pending_sums, want};
    endtask

    // Offer one item, idling at random first; valid stays high afterwards
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic [IDX_W-1:0] lo,
                             input logic [IDX_W-1:0] hi,
                             input logic [DATA_W-1:0] value,
                             input logic [IDX_W-1:0] pos);
        while (!quiet_run && $urandom_range(0, 99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {4'b0, pos, value, hi, lo};
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        predict_sums(act, lo, hi, value, pos);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    // Write the element count once the block is idle
    task automatic write_length(input int length);
        wait_results_drained();
        repeat (8) @(posedge clk);
        cfg_wdata <= length[LEN_W-1:0];
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        len_mirror = length;
    endtask

    // Draw one item, mostly well formed, some noise
    task automatic make_random_item(output logic [ACT_W-1:0] act,
                                    output logic [IDX_W-1:0] lo,
                                    output logic [IDX_W-1:0] hi,
                                    output logic [DATA_W-1:0] value,
                                    output logic [IDX_W-1:0] pos);
        int pick;
        int w;
        int e;
        pick  = $urandom_range(0, 99);
        lo    = IDX_W'($urandom_range(0, MAX_LENGTH - 1));
        hi    = IDX_W'($urandom_range(0, MAX_LENGTH - 1));
        value = $urandom();
        pos   = IDX_W'(random_written());
        if (pick < 35)
        begin
            act = ACT_LOAD;
            if ($urandom_range(0, 9) < 7)
            begin
                pos = IDX_W'(fill_cursor);
                fill_cursor = (fill_cursor + 1) % MAX_LENGTH;
            end
            else
                pos = IDX_W'($urandom_range(0, MAX_LENGTH - 1));
        end
        else if (pick < 75)
        begin
            act = ACT_ASSIGN;
            w = random_written();
            e = w;
            while (e < MAX_LENGTH - 1 && written_mask[e + 1] && e - w < 64)
                e++;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    lo = IDX_W'(w);
                    hi = IDX_W'($urandom_range(w, e));
                end
                6, 7: lo = IDX_W'(w);
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0: value = 32'h8000_0000;
                1: value = 32'h7fff_ffff;
                default: ;
            endcase
            if ($urandom_range(0, 1))
                pos = IDX_W'($urandom_range(w, e));
            if (!item_legal(act, lo, hi, pos))
            begin
                lo = IDX_W'(w);
                hi = IDX_W'(w);
            end
        end
        else if (pick < 95)
            act = ACT_READ;
        else
            act = ACT_SPARE;
    endtask

    // Loads at the extremes, repeated load, reads, length zero
    task automatic test_load_and_read();
        send_item(ACT_LOAD, 12'd0, 12'd0, 32'h7fff_ffff, 12'd0);
        send_item(ACT_LOAD, 12'hfff, 12'hfff, 32'h8000_0000, 12'd1);
        send_item(ACT_LOAD, 12'd0, 12'd0, 32'hffff_ffff, 12'hfff);
        send_item(ACT_LOAD, 12'd0, 12'd0, 32'd5, 12'd2);
        // repeated load adds on top of the old contribution
        send_item(ACT_LOAD, 12'd0, 12'd0, 32'd7, 12'd2);
        // nothing in use, so the assign changes nothing
        send_item(ACT_ASSIGN, 12'd0, 12'hfff, 32'd1234, 12'd2);
        send_item(ACT_READ, 12'hfff, 12'hfff, 32'hffff_ffff, 12'd2);
        send_item(ACT_SPARE, 12'd0, 12'd0, 32'd0, 12'd0);
    endtask

    // High index clamping, empty ranges, length at the extremes
    task automatic test_range_clamps();
        write_length(3);
        send_item(ACT_ASSIGN, 12'd0, 12'hfff, 32'h1234_5678, 12'd2);
        send_item(ACT_ASSIGN, 12'hfff, 12'd0, 32'hdead_beef, 12'd1);
        send_item(ACT_ASSIGN, 12'd3, 12'd5, 32'hdead_beef, 12'd0);
        send_item(ACT_READ, 12'd0, 12'd0, 32'd0, 12'd1);
        write_length(MAX_LENGTH);
        send_item(ACT_LOAD, 12'd0, 12'd0, 32'd0, 12'd4093);
        send_item(ACT_LOAD, 12'd0, 12'd0, 32'd1, 12'd4094);
        send_item(ACT_ASSIGN, 12'd4093, 12'hfff, 32'h8000_0000, 12'hfff);
        send_item(ACT_ASSIGN, 12'd0, 12'd1, 32'd0, 12'd0);
        write_length(1);
        send_item(ACT_ASSIGN, 12'd0, 12'hfff, -32'sd5, 12'd0);
        send_item(ACT_ASSIGN, 12'd1, 12'd1, 32'd9, 12'd1);
    endtask

    // Assign across the edge between two buckets
    task automatic test_bucket_boundary();
        write_length(300);
        send_item(ACT_LOAD, 12'd0, 12'd0, 32'd11, 12'd255);
        send_item(ACT_LOAD, 12'd0, 12'd0, 32'd22, 12'd256);
        send_item(ACT_ASSIGN, 12'd255, 12'd256, 32'd3, 12'd256);
        send_item(ACT_READ, 12'd0, 12'd0, 32'd0, 12'd255);
    endtask

    // Random items over four length settings, one stretch without stalls
    task automatic test_random_mix(input int count);
        logic [ACT_W-1:0]  act;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  pos;
        fill_cursor = $urandom_range(200, 250);
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_length($urandom_range(300, MAX_LENGTH));
                1: write_length(MAX_LENGTH);
                2: write_length($urandom_range(260, 400));
                default: write_length($urandom_range(0, MAX_LENGTH));
            endcase
            quiet_run = (phase == 2);
            for (int i = 0; i < count / 4; i++)
            begin
                make_random_item(act, lo, hi, value, pos);
                send_item(act, lo, hi, value, pos);
            end
        end
        quiet_run = 1'b0;
    endtask

    // Short bursts, each followed by a full pause until results drain
    task automatic test_drain_pause();
        logic [ACT_W-1:0]  act;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  pos;
        for (int round = 0; round < 3; round++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                make_random_item(act, lo, hi, value, pos);
                send_item(act, lo, hi, value, pos);
            end
            wait_results_drained();
        end
    endtask

    initial
    begin
        len_mirror = 0;
        for (int b = 0; b < BUCKET_COUNT; b++)
            bucket_mirror[b] = '0;
        for (int j = 0; j < MAX_LENGTH; j++)
            written_mask[j] = 1'b0;

        // Hold reset, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_and_read();
        test_range_clamps();
        test_bucket_boundary();
        test_random_mix(104);
        test_drain_pause();

        // Let the pipeline settle and catch stray results
        repeat (100) @(posedge clk);

        $display("Checked %0d results from %0d items, %0d range assigns rewriting %0d elements.",
                 results_seen, items_sent, assigns_sent, elems_rewritten);
        $display("Element counts from 0 to 4096, bucket edges, empty and clamped ranges.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
